// ===== hw/rtl/normalized_cross_product_assert.svh =====
// Assertion macros shared by the pipeline modules.
// All checks sample on clock and are disabled while reset is high.
`ifndef NORMALIZED_CROSS_PRODUCT_ASSERT_SVH
`define NORMALIZED_CROSS_PRODUCT_ASSERT_SVH

// Same-cycle implication.
`define NCP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define NCP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ncp_pkg.sv =====
`timescale 1ns / 1ps

package ncp_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned SizeWidth  = 6;
   localparam int unsigned LeftWidth  = 4;
   localparam int unsigned RightWidth = 5;
   localparam int unsigned CountWidth = 6;
   localparam int unsigned NormTarget = 30;
   localparam int unsigned LzCap      = 31;

   typedef logic signed [WordWidth-1:0] word_type;
   typedef logic [SizeWidth-1:0]        size_type;
   typedef logic [LeftWidth-1:0]        left_type;
   typedef logic [RightWidth-1:0]       right_type;
   typedef logic [CountWidth-1:0]       count_type;

   typedef struct packed {
      word_type first_x;
      word_type first_y;
      word_type first_z;
      word_type second_x;
      word_type second_y;
      word_type second_z;
      word_type origin_x;
      word_type origin_y;
      word_type origin_z;
      logic     use_origin;
   } ncp_req_type;

   typedef struct packed {
      word_type cross_x;
      word_type cross_y;
      word_type cross_z;
   } ncp_rsp_type;

   typedef struct packed {
      word_type x;
      word_type y;
      word_type z;
   } vec_type;

   typedef struct packed {
      vec_type a;
      vec_type b;
   } pair_type;

   typedef struct packed {
      pair_type pair;
      size_type size_a;
      size_type size_b;
   } sized_type;

   function automatic logic [WordWidth-1:0] magnitude(word_type v);
      logic [WordWidth-1:0] u;
      u = v;
      return u[WordWidth-1] ? (~u + {{(WordWidth-1){1'b0}}, 1'b1}) : u;
   endfunction

   // 32 minus the leading-zero count of the widest magnitude, count capped
   function automatic size_type vec_size(vec_type v);
      logic [WordWidth-1:0] m;
      size_type             lz;
      m  = magnitude(v.x) | magnitude(v.y) | magnitude(v.z);
      lz = SizeWidth'(LzCap);
      for (int i = 0; i < WordWidth; i++) begin
         if (m[i]) begin
            lz = SizeWidth'(WordWidth - 1 - i);
         end
      end
      return SizeWidth'(WordWidth) - lz;
   endfunction

   function automatic vec_type shift_vec(vec_type v, left_type l, right_type r);
      vec_type o;
      if (l != '0) begin
         o.x = v.x <<< l;
         o.y = v.y <<< l;
         o.z = v.z <<< l;
      end else begin
         o.x = v.x >>> r;
         o.y = v.y >>> r;
         o.z = v.z >>> r;
      end
      return o;
   endfunction

endpackage

// ===== hw/rtl/ncp_prep.sv =====
`timescale 1ns / 1ps
`include "normalized_cross_product_assert.svh"

module ncp_prep (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                hold_out,
   input  ncp_pkg::ncp_req_type in_data,
   output logic                out_valid,
   input  logic                hold_in,
   output ncp_pkg::sized_type  out_data
);

   logic              v1_ff, v1_in, v2_ff, v2_in;
   logic              en1, en2;
   ncp_pkg::pair_type p1_ff, p1_in;
   ncp_pkg::pair_type p2_ff;
   ncp_pkg::size_type sa2_ff, sa2_in, sb2_ff, sb2_in;
   ncp_pkg::word_type ox, oy, oz;

   assign en2      = !v2_ff || !hold_in;
   assign en1      = !v1_ff || en2;
   assign hold_out = !en1;
   assign v1_in    = en1 ? in_valid : v1_ff;
   assign v2_in    = en2 ? v1_ff : v2_ff;

   // stage 1: origin subtract
   always_comb begin
      ox = in_data.use_origin ? in_data.origin_x : '0;
      oy = in_data.use_origin ? in_data.origin_y : '0;
      oz = in_data.use_origin ? in_data.origin_z : '0;
      p1_in.a.x = in_data.first_x - ox;
      p1_in.a.y = in_data.first_y - oy;
      p1_in.a.z = in_data.first_z - oz;
      p1_in.b.x = in_data.second_x - ox;
      p1_in.b.y = in_data.second_y - oy;
      p1_in.b.z = in_data.second_z - oz;
   end

   // stage 2: vector bit sizes
   assign sa2_in = ncp_pkg::vec_size(p1_ff.a);
   assign sb2_in = ncp_pkg::vec_size(p1_ff.b);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         p1_ff <= p1_in;
      end
      if (en2) begin
         p2_ff  <= p1_ff;
         sa2_ff <= sa2_in;
         sb2_ff <= sb2_in;
      end
   end

   assign out_valid          = v2_ff;
   assign out_data.pair      = p2_ff;
   assign out_data.size_a    = sa2_ff;
   assign out_data.size_b    = sb2_ff;

   `NCP_ASSERT_NOW(a_size_range, v2_ff, (sa2_ff != '0) && (sb2_ff != '0) && (sa2_ff <= ncp_pkg::SizeWidth'(ncp_pkg::WordWidth)) && (sb2_ff <= ncp_pkg::SizeWidth'(ncp_pkg::WordWidth)), "vector size out of range")

endmodule

// ===== hw/rtl/ncp_scale.sv =====
`timescale 1ns / 1ps
`include "normalized_cross_product_assert.svh"

module ncp_scale (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               hold_out,
   input  ncp_pkg::sized_type in_data,
   output logic               out_valid,
   input  logic               hold_in,
   output ncp_pkg::pair_type  out_data
);

   localparam int unsigned MaxShift = ncp_pkg::WordWidth - 1;

   logic               v3_ff, v3_in, v4_ff, v4_in, v5_ff, v5_in;
   logic               en3, en4, en5;
   ncp_pkg::pair_type  p3_ff, p4_ff, p5_ff, p5_in;
   logic [6:0]         sum;
   logic [5:0]         n_raw;
   ncp_pkg::left_type  l3_ff, l3_in, l4_ff;
   ncp_pkg::count_type n3_ff, n3_in;
   logic [4:0]         gap3_ff, gap3_in;
   logic               abig3_ff, abig3_in, bbig3_ff, bbig3_in;
   ncp_pkg::count_type take, rest, ka_raw, kb_raw;
   ncp_pkg::right_type ka4_ff, ka4_in, kb4_ff, kb4_in;

   assign en5      = !v5_ff || !hold_in;
   assign en4      = !v4_ff || en5;
   assign en3      = !v3_ff || en4;
   assign hold_out = !en3;
   assign v3_in    = en3 ? in_valid : v3_ff;
   assign v4_in    = en4 ? v3_ff : v4_ff;
   assign v5_in    = en5 ? v4_ff : v5_ff;

   // stage 3: size sum, left amount, right-shift total, size gap
   always_comb begin
      sum   = {1'b0, in_data.size_a} + {1'b0, in_data.size_b};
      n_raw = 6'(sum - 7'(ncp_pkg::NormTarget - 1));
      l3_in = (sum < 7'(ncp_pkg::NormTarget))
            ? ncp_pkg::LeftWidth'((7'(ncp_pkg::NormTarget + 1) - sum) >> 1) : '0;
      n3_in = (sum > 7'(ncp_pkg::NormTarget)) ? {n_raw[5:1], 1'b0} : '0;
      abig3_in = in_data.size_a > in_data.size_b;
      bbig3_in = in_data.size_b > in_data.size_a;
      gap3_in  = abig3_in ? 5'(in_data.size_a - in_data.size_b)
                          : 5'(in_data.size_b - in_data.size_a);
   end

   // stage 4: closed-form split of right shifts, larger vector first
   always_comb begin
      take   = ({1'b0, gap3_ff} < n3_ff) ? {1'b0, gap3_ff} : n3_ff;
      rest   = n3_ff - take;
      ka_raw = (abig3_ff ? take : '0) + 6'(({1'b0, rest} + 7'd1) >> 1);
      kb_raw = (bbig3_ff ? take : '0) + (rest >> 1);
      ka4_in = (ka_raw > 6'(MaxShift)) ? 5'(MaxShift) : ka_raw[4:0];
      kb4_in = (kb_raw > 6'(MaxShift)) ? 5'(MaxShift) : kb_raw[4:0];
   end

   // stage 5: barrel shift
   assign p5_in.a = ncp_pkg::shift_vec(p4_ff.a, l4_ff, ka4_ff);
   assign p5_in.b = ncp_pkg::shift_vec(p4_ff.b, l4_ff, kb4_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         p3_ff    <= in_data.pair;
         l3_ff    <= l3_in;
         n3_ff    <= n3_in;
         gap3_ff  <= gap3_in;
         abig3_ff <= abig3_in;
         bbig3_ff <= bbig3_in;
      end
      if (en4) begin
         p4_ff  <= p3_ff;
         l4_ff  <= l3_ff;
         ka4_ff <= ka4_in;
         kb4_ff <= kb4_in;
      end
      if (en5) begin
         p5_ff <= p5_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_data  = p5_ff;

   `NCP_ASSERT_NOW(a_left_right_excl, v4_ff && (l4_ff != '0), (ka4_ff == '0) && (kb4_ff == '0), "left and right shift both set")
   `NCP_ASSERT_NEXT(a_stage4_fill, v3_ff && en4, v4_ff, "item lost between stages")

endmodule

// ===== hw/rtl/ncp_mul.sv =====
`timescale 1ns / 1ps
`include "normalized_cross_product_assert.svh"

module ncp_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 hold_out,
   input  ncp_pkg::pair_type    in_data,
   output logic                 out_valid,
   input  logic                 hold_in,
   output ncp_pkg::ncp_rsp_type out_data
);

   logic                 v6_ff, v6_in, v7_ff, v7_in;
   logic                 en6, en7;
   ncp_pkg::word_type    ay_bz_ff, ay_bz_in, by_az_ff, by_az_in;
   ncp_pkg::word_type    az_bx_ff, az_bx_in, bz_ax_ff, bz_ax_in;
   ncp_pkg::word_type    ax_by_ff, ax_by_in, bx_ay_ff, bx_ay_in;
   ncp_pkg::ncp_rsp_type rsp_ff, rsp_in;

   assign en7      = !v7_ff || !hold_in;
   assign en6      = !v6_ff || en7;
   assign hold_out = !en6;
   assign v6_in    = en6 ? in_valid : v6_ff;
   assign v7_in    = en7 ? v6_ff : v7_ff;

   // stage 6: low halves of the six products
   assign ay_bz_in = in_data.a.y * in_data.b.z;
   assign by_az_in = in_data.b.y * in_data.a.z;
   assign az_bx_in = in_data.a.z * in_data.b.x;
   assign bz_ax_in = in_data.b.z * in_data.a.x;
   assign ax_by_in = in_data.a.x * in_data.b.y;
   assign bx_ay_in = in_data.b.x * in_data.a.y;

   // stage 7: differences into the output register
   assign rsp_in.cross_x = ay_bz_ff - by_az_ff;
   assign rsp_in.cross_y = az_bx_ff - bz_ax_ff;
   assign rsp_in.cross_z = ax_by_ff - bx_ay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v6_ff <= v6_in;
         v7_ff <= v7_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en6) begin
         ay_bz_ff <= ay_bz_in;
         by_az_ff <= by_az_in;
         az_bx_ff <= az_bx_in;
         bz_ax_ff <= bz_ax_in;
         ax_by_ff <= ax_by_in;
         bx_ay_ff <= bx_ay_in;
      end
      if (en7) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = v7_ff;
   assign out_data  = rsp_ff;

   `NCP_ASSERT_NEXT(a_out_kept, v7_ff && hold_in, v7_ff, "result dropped while stalled")

endmodule

// ===== hw/rtl/normalized_cross_product.sv =====
// Throughput: one transfer per cycle unless stalled; seven register stages
// (origin subtract, size count, shift amounts, shift split, shift, multiply,
// subtract), bubbles fill on stall.
// Reset clears every stage valid bit; payload registers are not reset.
`timescale 1ns / 1ps

module normalized_cross_product (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ncp_pkg::ncp_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ncp_pkg::ncp_rsp_type rsp_data
);

   logic               prep_valid, scale_valid;
   logic               scale_hold, mul_hold;
   ncp_pkg::sized_type prep_data;
   ncp_pkg::pair_type  scale_data;

   ncp_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .hold_out  (req_stall),
      .in_data   (req_data),
      .out_valid (prep_valid),
      .hold_in   (scale_hold),
      .out_data  (prep_data)
   );

   ncp_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .hold_out  (scale_hold),
      .in_data   (prep_data),
      .out_valid (scale_valid),
      .hold_in   (mul_hold),
      .out_data  (scale_data)
   );

   ncp_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (scale_valid),
      .hold_out  (mul_hold),
      .in_data   (scale_data),
      .out_valid (rsp_valid),
      .hold_in   (rsp_stall),
      .out_data  (rsp_data)
   );

endmodule
